@@ design/ble_ad_structure_parser_defines.svh @@
// Assertion macros for the advertising data parser.
`ifndef BLE_AD_STRUCTURE_PARSER_DEFINES_SVH
`define BLE_AD_STRUCTURE_PARSER_DEFINES_SVH
// Assert that a condition implies a consequence in the same cycle.
`define BAP_ASSERT_IMPL(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("assertion failed");
// Assert that a condition implies a consequence in the next cycle.
`define BAP_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("assertion failed");
`endif

@@ design/bap_pkg.sv @@
// Shared types and constants for the advertising data parser.
package bap_pkg;
   localparam int MaxBlockBytes = 255;
   localparam logic [7:0] NameLimitReset = 8'd30;
   localparam int QueueDepth = 4;
   localparam int QueueAw = 2;

   typedef enum logic [1:0] {PH_LEN, PH_TYPE, PH_DATA, PH_STOP} phase_type;

   localparam logic [4:0] K_FLAGS = 5'd0, K_UUID16 = 5'd1, K_UUID32 = 5'd2,
      K_U128LO = 5'd3, K_U128HI = 5'd4, K_SNAME = 5'd5, K_NAME = 5'd6,
      K_TXPWR = 5'd7, K_CLASS = 5'd8, K_DEVID = 5'd9, K_APPEAR = 5'd10,
      K_COMPANY = 5'd11, K_MANUF = 5'd12, K_HASH = 5'd13, K_RAND = 5'd14,
      K_UNKNOWN = 5'd15, K_BLKEND = 5'd16;

   typedef struct packed {
      logic [7:0] ad_byte;
      logic [7:0] block_length;
      logic       first_byte;
   } req_type;

   typedef struct packed {
      logic [4:0]  record_kind;
      logic [63:0] value;
      logic        half_index;
      logic [6:0]  element_index;
      logic [1:0]  block_status;
   } rsp_type;

   // classified work for one accepted byte
   typedef struct packed {
      logic       rec_valid;
      rsp_type    rec;
      logic       end_valid;
      logic [6:0] end_count;
      logic [1:0] end_status;
   } work_type;

   function automatic logic type_is_known(input logic [7:0] t);
      return (t >= 8'h01 && t <= 8'h0A) || (t >= 8'h0D && t <= 8'h10) ||
             (t >= 8'h14 && t <= 8'h19) || (t >= 8'h1F && t <= 8'h21) ||
             (t == 8'hFF);
   endfunction
endpackage

@@ design/ble_ad_structure_parser.sv @@
// Top level of the advertising data LTV parser.
// Takes one byte per cycle when the output is not backed up; each byte gives
// zero to two records (an element record plus the block-end record on the
// last block byte). The parse state machine classifies a byte combinationally
// and hands it to a four-entry queue; the emitter drains one record a cycle
// while rsp_stall is low, and a byte yielding two records keeps its entry until both are taken.
module ble_ad_structure_parser (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  bap_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output bap_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [7:0]       csr_data
);
   logic [7:0] limit_ff;
   logic full, step, push;
   bap_pkg::work_type work;

   assign csr_ready = 1'b1;
   assign req_stall = full;
   assign step = req_valid && !full;
   assign push = step && (work.rec_valid || work.end_valid);

   always_ff @(posedge clock) begin
      if (reset) limit_ff <= bap_pkg::NameLimitReset;
      else if (csr_valid) limit_ff <= csr_data;
   end

   bap_front u_front (.clock, .reset, .step, .req(req_data),
                      .name_limit(limit_ff), .work);
   bap_back u_back (.clock, .reset, .push, .work, .full,
                    .rsp_valid, .rsp_stall, .rsp_data);
endmodule

@@ design/bap_front.sv @@
// Front end: LTV parse state machine, one byte per cycle while step is high, builds work entries.
module bap_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  bap_pkg::req_type  req,
   input  logic [7:0]        name_limit,
   output bap_pkg::work_type work
);
   bap_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  offset_ff, offset_in, remain_ff, remain_in, etype_ff, etype_in;
   logic [7:0]  pos_ff, pos_in;
   logic [63:0] acc_ff, acc_in;
   logic [6:0]  count_ff, count_in;
   logic [1:0]  stat_ff, stat_in;

   bap_pkg::phase_type ph;
   logic [7:0]  offs, rem, et, ps, b, size, p, rest, elen;
   logic [63:0] acc, accs;
   logic [6:0]  cnt, idx;
   logic [1:0]  st;
   logic [2:0]  lane;
   logic [8:0]  endpos;

   always_comb begin
      ph = phase_ff; offs = offset_ff; rem = remain_ff; et = etype_ff;
      ps = pos_ff; acc = acc_ff; cnt = count_ff; st = stat_ff;
      if (req.first_byte) begin
         ph = bap_pkg::PH_LEN; offs = '0; rem = '0; et = '0; ps = '0;
         acc = '0; cnt = '0; st = '0;
      end
      b = req.ad_byte;
      size = (req.block_length > 8'(bap_pkg::MaxBlockBytes)) ?
             8'(bap_pkg::MaxBlockBytes) : req.block_length;
      work = '0;
      idx = (cnt != 7'd0) ? cnt - 7'd1 : 7'd0;
      p = ps + 8'd1;
      elen = ps + rem;
      rest = elen - p;
      lane = 3'd0;
      accs = acc;
      endpos = {1'b0, offs} + 9'd1;
      if (offs < size) begin
         case (ph)
            bap_pkg::PH_LEN: begin
               if (b == 8'd0) begin
                  ph = bap_pkg::PH_STOP; st = 2'd1;
               end else if ({1'b0, offs} + 9'd1 + {1'b0, b} > {1'b0, size}) begin
                  ph = bap_pkg::PH_STOP; st = 2'd2;
               end else begin
                  if (cnt < 7'd127) cnt = cnt + 7'd1;
                  rem = b; ph = bap_pkg::PH_TYPE;
               end
            end
            bap_pkg::PH_TYPE: begin
               et = b; ps = '0; acc = '0; rem = rem - 8'd1;
               if (!bap_pkg::type_is_known(b)) begin
                  work.rec_valid = 1'b1;
                  work.rec.record_kind = bap_pkg::K_UNKNOWN;
                  work.rec.value = {56'd0, b};
                  work.rec.element_index = idx;
               end
               ph = (rem != 8'd0) ? bap_pkg::PH_DATA : bap_pkg::PH_LEN;
            end
            bap_pkg::PH_DATA: begin
               if (bap_pkg::type_is_known(et)) begin
                  if (et == 8'h02 || et == 8'h03) lane = {2'b00, ps[0]};
                  else if (et == 8'h04 || et == 8'h05) lane = {1'b0, ps[1:0]};
                  else lane = ps[2:0];
                  accs = (lane == 3'd0) ? 64'd0 : acc;
                  accs = accs | ({56'd0, b} << {lane, 3'b000});
                  acc = accs;
                  work.rec.element_index = idx;
                  work.rec.value = accs;
                  case (et)
                     8'h01: if (p == 8'd1) begin
                        work.rec_valid = 1'b1; work.rec.record_kind = bap_pkg::K_FLAGS;
                     end
                     8'h0A: if (p == 8'd1) begin
                        work.rec_valid = 1'b1; work.rec.record_kind = bap_pkg::K_TXPWR;
                     end
                     8'h02, 8'h03: if (lane == 3'd1) begin
                        work.rec_valid = 1'b1; work.rec.record_kind = bap_pkg::K_UUID16;
                     end
                     8'h04, 8'h05: if (lane == 3'd3) begin
                        work.rec_valid = 1'b1; work.rec.record_kind = bap_pkg::K_UUID32;
                     end
                     8'h06, 8'h07: if (lane == 3'd7) begin
                        if (!ps[3]) begin
                           work.rec_valid = (rest >= 8'd8);
                           work.rec.record_kind = bap_pkg::K_U128LO;
                        end else begin
                           work.rec_valid = 1'b1;
                           work.rec.record_kind = bap_pkg::K_U128HI;
                        end
                     end
                     8'h08: if (p <= name_limit) begin
                        work.rec_valid = 1'b1; work.rec.record_kind = bap_pkg::K_SNAME;
                     end
                     8'h09: if (p <= name_limit) begin
                        work.rec_valid = 1'b1; work.rec.record_kind = bap_pkg::K_NAME;
                     end
                     8'h0D: if (p == 8'd3) begin
                        work.rec_valid = 1'b1; work.rec.record_kind = bap_pkg::K_CLASS;
                     end
                     8'h0E, 8'h0F: if (elen >= 8'd16 && (p == 8'd8 || p == 8'd16)) begin
                        work.rec_valid = 1'b1;
                        work.rec.record_kind = (et == 8'h0E) ? bap_pkg::K_HASH
                                                             : bap_pkg::K_RAND;
                        work.rec.half_index = (p == 8'd16);
                     end
                     8'h10: if (p == 8'd8) begin
                        work.rec_valid = 1'b1; work.rec.record_kind = bap_pkg::K_DEVID;
                     end
                     8'h19: if (p == 8'd2) begin
                        work.rec_valid = 1'b1; work.rec.record_kind = bap_pkg::K_APPEAR;
                     end
                     8'hFF: if (p == 8'd2) begin
                        work.rec_valid = 1'b1; work.rec.record_kind = bap_pkg::K_COMPANY;
                     end else if (p > 8'd2) begin
                        work.rec_valid = 1'b1; work.rec.record_kind = bap_pkg::K_MANUF;
                     end
                     default: ;
                  endcase
                  // single-byte kinds carry the raw byte
                  if (work.rec.record_kind == bap_pkg::K_FLAGS ||
                      work.rec.record_kind == bap_pkg::K_TXPWR ||
                      work.rec.record_kind == bap_pkg::K_SNAME ||
                      work.rec.record_kind == bap_pkg::K_NAME ||
                      work.rec.record_kind == bap_pkg::K_MANUF)
                     work.rec.value = {56'd0, b};
               end
               ps = p;
               rem = rem - 8'd1;
               if (rem == 8'd0) ph = bap_pkg::PH_LEN;
            end
            default: ;
         endcase
         if (endpos == {1'b0, size}) begin
            work.end_valid = 1'b1;
            work.end_count = cnt;
            work.end_status = (ph == bap_pkg::PH_STOP) ? st :
                              ((ph == bap_pkg::PH_LEN) ? 2'd0 : 2'd2);
         end
         if (offs < 8'd255) offs = offs + 8'd1;
      end
      phase_in = ph; offset_in = offs; remain_in = rem; etype_in = et;
      pos_in = ps; acc_in = acc; count_in = cnt; stat_in = st;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= bap_pkg::PH_LEN; offset_ff <= '0; remain_ff <= '0;
         etype_ff <= '0; pos_ff <= '0; acc_ff <= '0; count_ff <= '0; stat_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in; offset_ff <= offset_in; remain_ff <= remain_in;
         etype_ff <= etype_in; pos_ff <= pos_in; acc_ff <= acc_in;
         count_ff <= count_in; stat_ff <= stat_in;
      end
   end
endmodule

@@ design/bap_back.sv @@
// Back end: work queue and record emitter, up to two records per entry.
module bap_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  bap_pkg::work_type work,
   output logic              full,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bap_pkg::rsp_type  rsp_data
);
   `include "ble_ad_structure_parser_defines.svh"
   bap_pkg::work_type q_ff [bap_pkg::QueueDepth];
   logic [bap_pkg::QueueAw-1:0] rd_ff, rd_in, wr_ff, wr_in;
   logic [bap_pkg::QueueAw:0] cnt_ff, cnt_in;
   logic second_ff, second_in;
   bap_pkg::work_type head;
   logic pop, take, has_rec;

   assign head = q_ff[rd_ff];
   assign full = (cnt_ff == bap_pkg::QueueAw'(0) + (bap_pkg::QueueAw+1)'(bap_pkg::QueueDepth));
   assign has_rec = head.rec_valid && !second_ff;
   assign rsp_valid = (cnt_ff != '0);
   assign take = rsp_valid && !rsp_stall;
   assign pop = take && (!has_rec || !head.end_valid);

   always_comb begin
      rsp_data = head.rec;
      if (!has_rec) begin
         rsp_data = '0;
         rsp_data.record_kind = bap_pkg::K_BLKEND;
         rsp_data.value = {57'd0, head.end_count};
         rsp_data.block_status = head.end_status;
      end
      rd_in = pop ? rd_ff + 1'b1 : rd_ff;
      wr_in = push ? wr_ff + 1'b1 : wr_ff;
      cnt_in = cnt_ff + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
      second_in = pop ? 1'b0 : (take ? 1'b1 : second_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff <= '0; wr_ff <= '0; cnt_ff <= '0; second_ff <= 1'b0;
      end else begin
         rd_ff <= rd_in; wr_ff <= wr_in; cnt_ff <= cnt_in; second_ff <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ff] <= work;
   end

   `BAP_ASSERT_IMPL(a_no_overflow, clock, reset, full, !push)
   `BAP_ASSERT_IMPL(a_second_end, clock, reset, second_ff && rsp_valid, head.end_valid)
   `BAP_ASSERT_NEXT(a_cnt_track, clock, reset, push && !pop, cnt_ff != '0)
endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for the advertising data element parser.
module tb_top;
   import bap_pkg::*;

   logic clock, reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall;
   logic csr_valid, csr_ready;
   logic [7:0] csr_data;
   req_type req_data;
   rsp_type rsp_data;

   ble_ad_structure_parser dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("Mismatches found");
      $finish;
   end

   // parser state mirror
   rsp_type    pending_records[$];
   logic [7:0] name_cap;
   phase_type  phase;
   logic [7:0] offset, remaining, cur_type, elem_pos;
   logic [63:0] accum;
   logic [6:0] elem_count;
   logic [1:0] stop_code;
   int mismatch_count = 0, records_seen = 0, bytes_sent = 0, blocks_sent = 0;
   int sender_idle_pct = 0, receiver_idle_pct = 0;

   function automatic bit decoded_type(logic [7:0] t);
      return (t >= 8'h01 && t <= 8'h0A) || (t >= 8'h0D && t <= 8'h10) ||
             (t >= 8'h14 && t <= 8'h19) || (t >= 8'h1F && t <= 8'h21) ||
             t == 8'hFF;
   endfunction

   function automatic void emit(logic [4:0] kind, logic [63:0] val, logic half,
                                logic [6:0] idx, logic [1:0] st);
      rsp_type r;
      r.record_kind = kind; r.value = val; r.half_index = half;
      r.element_index = idx; r.block_status = st;
      pending_records.insert(pending_records.size(), r);
   endfunction

   function automatic void clear_parse();
      phase = PH_LEN; offset = 0; remaining = 0; cur_type = 0; elem_pos = 0;
      accum = 0; elem_count = 0; stop_code = 0;
   endfunction

   function automatic void decode_data(logic [7:0] b);
      int elen, p, rest, g, lane;
      logic [6:0] idx;
      elen = elem_pos + remaining;
      p = elem_pos + 1;
      rest = elen - p;
      idx = elem_count ? elem_count - 7'd1 : 7'd0;
      g = 8;
      if (cur_type == 8'h02 || cur_type == 8'h03) g = 2;
      else if (cur_type == 8'h04 || cur_type == 8'h05) g = 4;
      lane = (p - 1) & (g - 1);
      if (lane == 0) accum = 0;
      accum |= 64'(b) << (8 * lane);
      case (cur_type)
         8'h01: if (p == 1) emit(K_FLAGS, 64'(b), 0, idx, 0);
         8'h0A: if (p == 1) emit(K_TXPWR, 64'(b), 0, idx, 0);
         8'h02, 8'h03: if (lane == 1) emit(K_UUID16, accum, 0, idx, 0);
         8'h04, 8'h05: if (lane == 3) emit(K_UUID32, accum, 0, idx, 0);
         8'h06, 8'h07: if (lane == 7) begin
            if (((p - 1) >> 3) % 2 == 0) begin
               if (rest >= 8) emit(K_U128LO, accum, 0, idx, 0);
            end else emit(K_U128HI, accum, 0, idx, 0);
         end
         8'h08: if (p <= name_cap) emit(K_SNAME, 64'(b), 0, idx, 0);
         8'h09: if (p <= name_cap) emit(K_NAME, 64'(b), 0, idx, 0);
         8'h0D: if (p == 3) emit(K_CLASS, accum, 0, idx, 0);
         8'h0E, 8'h0F: if (elen >= 16 && (p == 8 || p == 16))
            emit(cur_type == 8'h0E ? K_HASH : K_RAND, accum, p == 16, idx, 0);
         8'h10: if (p == 8) emit(K_DEVID, accum, 0, idx, 0);
         8'h19: if (p == 2) emit(K_APPEAR, accum, 0, idx, 0);
         8'hFF: if (p == 2) emit(K_COMPANY, accum, 0, idx, 0);
            else if (p > 2) emit(K_MANUF, 64'(b), 0, idx, 0);
         default: ;
      endcase
      elem_pos = 8'(p);
   endfunction

   function automatic void parse_byte(req_type r);
      int size;
      logic [1:0] st;
      if (r.first_byte) clear_parse();
      size = r.block_length;
      if (size > MaxBlockBytes) size = MaxBlockBytes;
      if (offset >= size) return;
      case (phase)
         PH_LEN: begin
            if (r.ad_byte == 0) begin
               phase = PH_STOP; stop_code = 1;
            end else if (offset + 1 + r.ad_byte > size) begin
               phase = PH_STOP; stop_code = 2;
            end else begin
               if (elem_count < 127) elem_count++;
               remaining = r.ad_byte;
               phase = PH_TYPE;
            end
         end
         PH_TYPE: begin
            cur_type = r.ad_byte; elem_pos = 0; accum = 0;
            remaining--;
            if (!decoded_type(r.ad_byte))
               emit(K_UNKNOWN, 64'(r.ad_byte), 0,
                    elem_count ? elem_count - 7'd1 : 7'd0, 0);
            phase = remaining ? PH_DATA : PH_LEN;
         end
         PH_DATA: begin
            if (decoded_type(cur_type)) decode_data(r.ad_byte);
            else elem_pos++;
            remaining--;
            if (remaining == 0) phase = PH_LEN;
         end
         default: ;
      endcase
      if (offset + 1 == size) begin
         st = phase == PH_STOP ? stop_code : (phase == PH_LEN ? 2'd0 : 2'd2);
         emit(K_BLKEND, 64'(elem_count), 0, 0, st);
      end
      if (offset < 255) offset++;
   endfunction

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         records_seen++;
         if (pending_records.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected record, expected none, actual %h", $time, rsp_data);
         end else begin
            rsp_type e;
            e = pending_records.pop_front();
            if (rsp_data.record_kind !== e.record_kind || rsp_data.value !== e.value ||
                rsp_data.half_index !== e.half_index ||
                rsp_data.element_index !== e.element_index ||
                rsp_data.block_status !== e.block_status) begin
               mismatch_count++;
               $display("%0t: record mismatch, expected %h, actual %h", $time, e, rsp_data);
            end
         end
      end
   end

   always @(negedge clock)
      rsp_stall <= reset ? 1'b0 : ($urandom_range(99) < receiver_idle_pct);

   task automatic push_byte(req_type r, bit typed = 0, rsp_type typed_rec = '0);
      int prior_count;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid = 0;
         @(negedge clock);
      end
      req_valid = 1;
      req_data = r;
      do @(posedge clock); while (req_stall);
      prior_count = pending_records.size();
      parse_byte(r);
      if (typed) begin
         while (pending_records.size() > prior_count) void'(pending_records.pop_back());
         pending_records.insert(pending_records.size(), typed_rec);
      end
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid = 0;
      while (pending_records.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_name_cap(logic [7:0] v);
      csr_valid = 1;
      csr_data = v;
      do @(posedge clock); while (!csr_ready);
      name_cap = v;
      @(negedge clock);
      csr_valid = 0;
   endtask

   function automatic req_type mk(logic [7:0] b, logic [7:0] len, logic first);
      req_type r;
      r.ad_byte = b; r.block_length = len; r.first_byte = first;
      return r;
   endfunction

   task automatic random_block();
      logic [7:0] blk[$];
      logic [7:0] types[18] = '{8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
         8'h08, 8'h09, 8'h0A, 8'h0D, 8'h0E, 8'h0F, 8'h10, 8'h14, 8'h19, 8'h20, 8'hFF};
      int size, dlen, pick;
      logic [7:0] t, len_now;
      size = ($urandom_range(99) < 4) ? 255 : $urandom_range(1, 40);
      if ($urandom_range(99) < 10) begin
         repeat (size) blk.insert(blk.size(), 8'($urandom_range(255)));
      end else begin
         while (blk.size() < size) begin
            pick = $urandom_range(99);
            if (pick < 4) begin
               blk.insert(blk.size(), 8'd0);
               while (blk.size() < size) blk.insert(blk.size(), 8'($urandom_range(255)));
            end else if (pick < 8) begin
               blk.insert(blk.size(), 8'(size - blk.size() + $urandom_range(0, 5)));
               while (blk.size() < size) blk.insert(blk.size(), 8'($urandom_range(255)));
            end else if (blk.size() + 1 == size) begin
               blk.insert(blk.size(), 8'($urandom_range(255)));
            end else begin
               t = ($urandom_range(99) < 8) ? 8'($urandom_range(255))
                                           : types[$urandom_range(17)];
               dlen = (t == 8'h08 || t == 8'h09 || t == 8'h06 || t == 8'h07 ||
                       t == 8'hFF) ? $urandom_range(0, 40) : $urandom_range(0, 20);
               if (blk.size() + 2 + dlen > size) dlen = size - blk.size() - 2;
               blk.insert(blk.size(), 8'(dlen + 1));
               blk.insert(blk.size(), t);
               repeat (dlen) blk.insert(blk.size(), 8'($urandom_range(255)));
            end
         end
      end
      len_now = 8'(size);
      foreach (blk[i]) begin
         if (i > 0 && $urandom_range(999) < 3) len_now = $urandom_range(255);
         push_byte(mk(blk[i], len_now, i == 0));
      end
      if ($urandom_range(99) < 10)
         repeat ($urandom_range(1, 3)) push_byte(mk($urandom_range(255), len_now, 0));
      blocks_sent++;
   endtask

   typedef struct {
      req_type r;
      bit      typed;
      rsp_type rec;
   } step_row;

   initial begin
      step_row rows[$];
      rsp_type none;
      none = '0;
      req_valid = 0; req_data = '0; csr_valid = 0; csr_data = 0; rsp_stall = 0;
      name_cap = NameLimitReset;
      clear_parse();
      reset = 1;
      repeat (8) @(negedge clock);
      reset = 0;
      write_name_cap(8'd30);

      // flags, tx power, appearance, unknown, company, name, then block end
      rows.insert(rows.size(), '{mk(8'd2, 8'd20, 1), 0, none});
      rows.insert(rows.size(), '{mk(8'h01, 8'd20, 0), 0, none});
      rows.insert(rows.size(), '{mk(8'h06, 8'd20, 0), 1, '{K_FLAGS, 64'h06, 0, 0, 0}});
      rows.insert(rows.size(), '{mk(8'd2, 8'd20, 0), 0, none});
      rows.insert(rows.size(), '{mk(8'h0A, 8'd20, 0), 0, none});
      rows.insert(rows.size(), '{mk(8'h80, 8'd20, 0), 1, '{K_TXPWR, 64'h80, 0, 1, 0}});
      rows.insert(rows.size(), '{mk(8'd3, 8'd20, 0), 0, none});
      rows.insert(rows.size(), '{mk(8'h19, 8'd20, 0), 0, none});
      rows.insert(rows.size(), '{mk(8'h40, 8'd20, 0), 0, none});
      rows.insert(rows.size(), '{mk(8'h03, 8'd20, 0), 1, '{K_APPEAR, 64'h0340, 0, 2, 0}});
      rows.insert(rows.size(), '{mk(8'd1, 8'd20, 0), 0, none});
      rows.insert(rows.size(), '{mk(8'h42, 8'd20, 0), 1, '{K_UNKNOWN, 64'h42, 0, 3, 0}});
      rows.insert(rows.size(), '{mk(8'd3, 8'd20, 0), 0, none});
      rows.insert(rows.size(), '{mk(8'hFF, 8'd20, 0), 0, none});
      rows.insert(rows.size(), '{mk(8'h34, 8'd20, 0), 0, none});
      rows.insert(rows.size(), '{mk(8'h12, 8'd20, 0), 0, none});
      rows.insert(rows.size(), '{mk(8'd3, 8'd20, 0), 0, none});
      rows.insert(rows.size(), '{mk(8'h09, 8'd20, 0), 0, none});
      rows.insert(rows.size(), '{mk(8'h41, 8'd20, 0), 0, none});
      rows.insert(rows.size(), '{mk(8'hFF, 8'd20, 0), 0, none});
      // zero length stop, then bytes ignored until the block end
      rows.insert(rows.size(), '{mk(8'd0, 8'd3, 1), 0, none});
      rows.insert(rows.size(), '{mk(8'hFF, 8'd3, 0), 0, none});
      rows.insert(rows.size(), '{mk(8'hFF, 8'd3, 0), 1, '{K_BLKEND, 64'd0, 0, 0, 2'd1}});
      // element overruns the block
      rows.insert(rows.size(), '{mk(8'd9, 8'd2, 1), 0, none});
      rows.insert(rows.size(), '{mk(8'h01, 8'd2, 0), 1, '{K_BLKEND, 64'd0, 0, 0, 2'd2}});
      rows.insert(rows.size(), '{mk(8'h55, 8'd2, 0), 0, none});
      rows.insert(rows.size(), '{mk(8'h01, 8'd0, 1), 0, none});
      rows.insert(rows.size(), '{mk(8'd0, 8'd255, 1), 0, none});
      foreach (rows[i]) push_byte(rows[i].r, rows[i].typed, rows[i].rec);
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         int start;
         case (ph)
            0: begin sender_idle_pct = 16; receiver_idle_pct = 58; end
            1: begin sender_idle_pct = 58; receiver_idle_pct = 16; end
            2: begin sender_idle_pct = 0; receiver_idle_pct = 0; end
            default: begin sender_idle_pct = 16; receiver_idle_pct = 58; end
         endcase
         case (ph)
            0: write_name_cap(8'd0);
            1: write_name_cap(8'd255);
            2: write_name_cap($urandom_range(1, 40));
            default: write_name_cap(8'd30);
         endcase
         start = bytes_sent;
         while (bytes_sent - start < 310) random_block();
         drain();
      end

      repeat (50) @(negedge clock);
      $display("Covered %0d bytes in %0d random blocks, %0d records checked,",
               bytes_sent, blocks_sent, records_seen);
      $display("four name limits and three handshake idling mixes.");
      if (mismatch_count == 0 && pending_records.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule

@@ filelist.f @@
+incdir+design
design/bap_pkg.sv
design/bap_front.sv
design/bap_back.sv
design/ble_ad_structure_parser.sv
test/tb_top.sv
